FILE: design/calendar_date_counter_macros.svh
// Assertion macros shared by the date counter checks.
`ifndef CALENDAR_DATE_COUNTER_MACROS_SVH
`define CALENDAR_DATE_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define CDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define CDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/cdc_pkg.sv
// Shared types, constants and the month length function of the date counter.
package cdc_pkg;

  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int SET_YEAR_W = 12;
  localparam int YEAR_BITS  = 12;
  localparam int OUT_YEAR_W = YEAR_BITS;
  localparam int COUNT_W    = 16;

  localparam logic [SET_YEAR_W-1:0] SET_YEAR_LOW  = 12'd1900;
  localparam logic [SET_YEAR_W-1:0] SET_YEAR_HIGH = 12'd2100;

  localparam logic ACT_SET     = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [MONTH_W-1:0]    set_month;
    logic [DAY_W-1:0]      set_day;
    logic [SET_YEAR_W-1:0] set_year;
    logic [COUNT_W-1:0]    advance_days;
  } cdc_in_t;

  typedef struct packed {
    logic [MONTH_W-1:0]    month;
    logic [DAY_W-1:0]      day;
    logic [OUT_YEAR_W-1:0] year;
  } cdc_out_t;

  // Position of the year inside its century and of the century inside the
  // 400-year cycle; together with the two low year bits they give the leap rule.
  typedef struct packed {
    logic [6:0] yr_in_cent;
    logic [1:0] cent_in_cycle;
  } cdc_cent_t;

  function automatic logic is_leap(input logic [1:0] year_lsb, input cdc_cent_t cent);
    is_leap = (year_lsb == 2'd0) &&
              ((cent.yr_in_cent != 7'd0) || (cent.cent_in_cycle == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
    unique case (month)
      4'd2:                      month_days = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_days = 5'd30;
      default:                   month_days = 5'd31;
    endcase
  endfunction

endpackage

FILE: design/cdc_load.sv
// Validates a set request and produces the corrected date and century position.
module cdc_load (
  input  logic [cdc_pkg::MONTH_W-1:0]    set_month,
  input  logic [cdc_pkg::DAY_W-1:0]      set_day,
  input  logic [cdc_pkg::SET_YEAR_W-1:0] set_year,
  output logic [cdc_pkg::MONTH_W-1:0]    month_o,
  output logic [cdc_pkg::DAY_W-1:0]      day_o,
  output logic [cdc_pkg::SET_YEAR_W-1:0] year_o,
  output cdc_pkg::cdc_cent_t             cent_o
);
  import cdc_pkg::*;

  logic [7:0] ydiff;
  logic       leap;

  always_comb begin
    month_o = ((set_month >= 4'd1) && (set_month <= 4'd12)) ? set_month : 4'd1;
    year_o  = ((set_year >= SET_YEAR_LOW) && (set_year <= SET_YEAR_HIGH)) ?
              set_year : SET_YEAR_LOW;
    // Loaded years span 1900..2100, so the offset fits in eight bits.
    ydiff   = 8'(year_o - SET_YEAR_LOW);
    if (ydiff < 8'd100) begin
      cent_o.yr_in_cent    = ydiff[6:0];
      cent_o.cent_in_cycle = 2'd3;
    end else if (ydiff < 8'd200) begin
      cent_o.yr_in_cent    = 7'(ydiff - 8'd100);
      cent_o.cent_in_cycle = 2'd0;
    end else begin
      cent_o.yr_in_cent    = 7'd0;
      cent_o.cent_in_cycle = 2'd1;
    end
    leap  = is_leap(year_o[1:0], cent_o);
    day_o = ((set_day >= 5'd1) && (set_day <= month_days(month_o, leap))) ?
            set_day : 5'd1;
  end

endmodule

FILE: design/cdc_step.sv
// One-day step unit: gives the date that follows the given one, saturating.
module cdc_step (
  input  logic [cdc_pkg::MONTH_W-1:0]   month_i,
  input  logic [cdc_pkg::DAY_W-1:0]     day_i,
  input  logic [cdc_pkg::YEAR_BITS-1:0] year_i,
  input  cdc_pkg::cdc_cent_t            cent_i,
  output logic [cdc_pkg::MONTH_W-1:0]   month_o,
  output logic [cdc_pkg::DAY_W-1:0]     day_o,
  output logic [cdc_pkg::YEAR_BITS-1:0] year_o,
  output cdc_pkg::cdc_cent_t            cent_o
);
  import cdc_pkg::*;

  localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};

  logic             leap;
  logic [DAY_W-1:0] len;

  always_comb begin
    leap    = is_leap(year_i[1:0], cent_i);
    len     = month_days(month_i, leap);
    month_o = month_i;
    day_o   = day_i;
    year_o  = year_i;
    cent_o  = cent_i;
    priority if (day_i < len) begin
      day_o = day_i + 5'd1;
    end else if (month_i < 4'd12) begin
      month_o = month_i + 4'd1;
      day_o   = 5'd1;
    end else if (year_i != YEAR_MAX) begin
      year_o  = year_i + YEAR_BITS'(1);
      month_o = 4'd1;
      day_o   = 5'd1;
      if (cent_i.yr_in_cent == 7'd99) begin
        cent_o.yr_in_cent    = 7'd0;
        cent_o.cent_in_cycle = cent_i.cent_in_cycle + 2'd1;
      end else begin
        cent_o.yr_in_cent = cent_i.yr_in_cent + 7'd1;
      end
    end
  end

endmodule

FILE: design/calendar_date_counter.sv
// Gregorian date counter: set and day-by-day advance over one shared step unit.
// A set or an advance of zero or one day shows its result in the cycle after
// the request; an advance of N days makes one step unit pass per day.
// Throughput: one request at a time; a new one is taken once stepping ends and the
// result register is free or being read. Reset (rst_n low, synchronous) gives 1/1/1900.
module calendar_date_counter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  cdc_pkg::cdc_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output cdc_pkg::cdc_out_t out_data
);
  import cdc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                 state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MONTH_W-1:0]   month_r, month_nxt;
  logic [DAY_W-1:0]     day_r, day_nxt;
  logic [YEAR_BITS-1:0] year_r, year_nxt;
  cdc_cent_t            cent_r, cent_nxt;

  logic [MONTH_W-1:0]    ld_month;
  logic [DAY_W-1:0]      ld_day;
  logic [SET_YEAR_W-1:0] ld_year;
  cdc_cent_t             ld_cent;

  logic [MONTH_W-1:0]   st_month;
  logic [DAY_W-1:0]     st_day;
  logic [YEAR_BITS-1:0] st_year;
  cdc_cent_t            st_cent;

  logic accept;

  cdc_load u_load (
    .set_month (in_data.set_month),
    .set_day   (in_data.set_day),
    .set_year  (in_data.set_year),
    .month_o   (ld_month),
    .day_o     (ld_day),
    .year_o    (ld_year),
    .cent_o    (ld_cent)
  );

  cdc_step u_step (
    .month_i (month_r),
    .day_i   (day_r),
    .year_i  (year_r),
    .cent_i  (cent_r),
    .month_o (st_month),
    .day_o   (st_day),
    .year_o  (st_year),
    .cent_o  (st_cent)
  );

  // The date registers double as the result register, so they must hold
  // while an unread result is waiting.
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    out_data.month = month_r;
    out_data.day   = day_r;
    out_data.year  = year_r[OUT_YEAR_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cnt_nxt       = cnt_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    year_nxt      = year_r;
    cent_nxt      = cent_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.action == ACT_SET) begin
            month_nxt     = ld_month;
            day_nxt       = ld_day;
            year_nxt      = YEAR_BITS'(ld_year);
            cent_nxt      = ld_cent;
            out_valid_nxt = 1'b1;
          end else if (in_data.advance_days == '0) begin
            out_valid_nxt = 1'b1;
          end else begin
            month_nxt = st_month;
            day_nxt   = st_day;
            year_nxt  = st_year;
            cent_nxt  = st_cent;
            if (in_data.advance_days == COUNT_W'(1)) begin
              out_valid_nxt = 1'b1;
            end else begin
              cnt_nxt   = in_data.advance_days - COUNT_W'(1);
              state_nxt = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        month_nxt = st_month;
        day_nxt   = st_day;
        year_nxt  = st_year;
        cent_nxt  = st_cent;
        cnt_nxt   = cnt_r - COUNT_W'(1);
        if (cnt_r == COUNT_W'(1)) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r              <= ST_IDLE;
      out_valid_r          <= 1'b0;
      cnt_r                <= '0;
      month_r              <= 4'd1;
      day_r                <= 5'd1;
      year_r               <= YEAR_BITS'(SET_YEAR_LOW);
      cent_r.yr_in_cent    <= 7'd0;
      cent_r.cent_in_cycle <= 2'd3;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      year_r      <= year_nxt;
      cent_r      <= cent_nxt;
    end
  end

endmodule

FILE: design/cdc_checker.sv
// Port-level checks of the date counter and the bind that attaches them.
`include "calendar_date_counter_macros.svh"

module cdc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input cdc_pkg::cdc_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input cdc_pkg::cdc_out_t out_data
);
  import cdc_pkg::*;

  logic date_ok;

  assign date_ok = (out_data.month >= 4'd1) && (out_data.month <= 4'd12) &&
                   (out_data.day >= 5'd1) && (out_data.day <= 5'd31) &&
                   (out_data.year >= SET_YEAR_LOW);

  // A shown result always carries a legal date.
  `CDC_ASSERT_NOW(a_date_legal, out_valid, date_ok, "result date out of range")
  // No new request is taken while a result is blocked downstream.
  `CDC_ASSERT_NOW(a_hold_input, out_valid && out_stall, in_stall, "request taken over a blocked result")
  // A set request answers in the next cycle.
  `CDC_ASSERT_NEXT(a_set_latency, in_valid && !in_stall && (in_data.action == ACT_SET), out_valid, "set result late")
  // A blocked result stays on the port unchanged.
  `CDC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "blocked result changed")

endmodule

bind calendar_date_counter cdc_checker u_cdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
